/* hdl/ps_adpcm_nine_byte_decoder_defines.svh */
// ----------------------------------------------------------------------------
// ps_adpcm_nine_byte_decoder_defines
// Assertion macros shared by the checker of the nine-byte ADPCM decoder.
// ----------------------------------------------------------------------------
`ifndef PS_ADPCM_NINE_BYTE_DECODER_DEFINES_SVH
`define PS_ADPCM_NINE_BYTE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSADPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSADPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/psadpcm_pkg.sv */
// ----------------------------------------------------------------------------
// psadpcm_pkg
// Types, widths, constants and tap tables of the nine-byte ADPCM decoder.
// ----------------------------------------------------------------------------
package psadpcm_pkg;

  localparam int FRAC_BITS = 6;
  localparam int HIST_W    = 22;
  localparam int COEF_W    = 8;
  localparam int PROD_W    = HIST_W + COEF_W;
  localparam int FLR_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W     = 26;
  localparam int SAMPLE_W  = 16;

  localparam logic [3:0] LAST_DATA_POS = 4'd8;
  localparam logic [3:0] SHIFT_MAX     = 4'd12;
  localparam logic [3:0] PRED_MAX      = 4'd4;
  localparam logic [4:0] BASE_TOP      = 5'd18;
  localparam logic [1:0] CC_MONO       = 2'd1;
  localparam logic [1:0] CC_STEREO     = 2'd2;

  localparam logic signed [ACC_W-1:0] SAT_HI = 26'sd2097088;
  localparam logic signed [ACC_W-1:0] SAT_LO = -26'sd2097152;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_O,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  typedef struct packed {
    mac_ctrl_t mac;
    logic      use_older;
    logic      hist_wr;
    logic      hist_clr;
    logic      ch;
    logic      last;
  } seq_ctrl_t;

  function automatic logic signed [COEF_W-1:0] tap_newer(input logic [2:0] p);
    logic signed [COEF_W-1:0] c;
    case (p)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] tap_older(input logic [2:0] p);
    logic signed [COEF_W-1:0] c;
    case (p)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

/* hdl/psadpcm_mac.sv */
// ----------------------------------------------------------------------------
// psadpcm_mac
// Shared multiply-accumulate unit: one registered, floored product per enabled
// cycle, and an accumulator that loads nibble base plus product, or adds it.
// ----------------------------------------------------------------------------
module psadpcm_mac import psadpcm_pkg::*; (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [HIST_W-1:0] hist,
  input  logic signed [ACC_W-1:0]  base,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] product;
  logic signed [FLR_W-1:0]  prod;

  assign product = coef * hist;

  // Dropping the fraction bits of a two's complement product floors it.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= product[PROD_W-1:FRAC_BITS];
    end
    if (ctrl.acc_load) begin
      acc <= base + ACC_W'(prod);
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

/* hdl/psadpcm_seq.sv */
// ----------------------------------------------------------------------------
// psadpcm_seq
// Block sequencer: tracks header and byte position, holds the block's
// predictor and shift, and steps the shared unit through each nibble.
// ----------------------------------------------------------------------------
module psadpcm_seq import psadpcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_new,
  input  logic                     stereo,
  input  logic                     out_free,
  output seq_ctrl_t                ctrl,
  output logic signed [COEF_W-1:0] coef,
  output logic signed [ACC_W-1:0]  base
);

  state_t     state, state_next;
  logic [3:0] byte_pos;
  logic       cur_ch;
  logic [2:0] pred;
  logic [3:0] shift;
  logic [7:0] dbyte;
  logic       nib_sel;

  logic       accept;
  logic       is_header;
  logic [2:0] hdr_pred;
  logic [3:0] hdr_shift;
  logic [3:0] nib;
  logic [4:0] sh_amt;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // A new stream always restarts at a header byte.
  assign is_header = in_new || (byte_pos == 4'd0);
  assign hdr_pred  = (in_byte[7:4] > PRED_MAX) ? 3'd0 : in_byte[6:4];
  assign hdr_shift = (in_byte[3:0] > SHIFT_MAX) ? SHIFT_MAX : in_byte[3:0];

  assign nib    = nib_sel ? dbyte[7:4] : dbyte[3:0];
  assign sh_amt = BASE_TOP - {1'b0, shift};
  assign base   = $signed({{(ACC_W-4){nib[3]}}, nib}) <<< sh_amt;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !is_header) begin
          state_next = ST_MUL_N;
        end
      end
      ST_MUL_N: state_next = ST_MUL_O;
      ST_MUL_O: state_next = ST_ADD;
      ST_ADD:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = nib_sel ? ST_IDLE : ST_MUL_N;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.ch   = cur_ch;
    ctrl.last = nib_sel;
    case (state)
      ST_IDLE: ctrl.hist_clr = accept && in_new;
      ST_MUL_N: ctrl.mac.mul_en = 1'b1;
      ST_MUL_O: begin
        ctrl.mac.mul_en   = 1'b1;
        ctrl.mac.acc_load = 1'b1;
        ctrl.use_older    = 1'b1;
      end
      ST_ADD: ctrl.mac.acc_add = 1'b1;
      ST_OUT: ctrl.hist_wr = out_free;
      default: ctrl = '0;
    endcase
    coef = ctrl.use_older ? tap_older(pred) : tap_newer(pred);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      byte_pos <= 4'd0;
      cur_ch   <= 1'b0;
      pred     <= 3'd0;
      shift    <= 4'd0;
      nib_sel  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_new) begin
          cur_ch <= 1'b0;
        end
        if (is_header) begin
          pred     <= hdr_pred;
          shift    <= hdr_shift;
          byte_pos <= 4'd1;
        end else begin
          dbyte   <= in_byte;
          nib_sel <= 1'b0;
        end
      end
      if (state == ST_OUT && out_free) begin
        if (!nib_sel) begin
          nib_sel <= 1'b1;
        end else if (byte_pos == LAST_DATA_POS) begin
          byte_pos <= 4'd0;
          cur_ch   <= stereo ? ~cur_ch : 1'b0;
        end else begin
          byte_pos <= byte_pos + 4'd1;
        end
      end
    end
  end

endmodule

/* hdl/ps_adpcm_nine_byte_decoder.sv */
// Header byte: taken while idle, no output words.
// Data byte: each nibble, low first, steps through ST_MUL_N, ST_MUL_O, ST_ADD
// and ST_OUT, which registers its sample once the output is free; no new byte
// is taken before both samples are registered, as the shared multiplier-
// accumulator forms two products a sample. Synchronous active-high reset clears
// history, block position, channel, the output valid and sets channel_count to mono.
// ----------------------------------------------------------------------------
// ps_adpcm_nine_byte_decoder
// Nine-byte block ADPCM decoder with per-channel two-tap prediction.
// ----------------------------------------------------------------------------
module ps_adpcm_nine_byte_decoder import psadpcm_pkg::*; #(
  parameter int MAX_CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tuser,   // [0] new_stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample
  output logic                m_tuser,   // [0] channel
  output logic                m_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [1:0]                channel_count;
  logic                      stereo;
  logic                      out_free;
  seq_ctrl_t                 ctrl;
  logic signed [COEF_W-1:0]  coef;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc;
  logic signed [HIST_W-1:0]  hist_n [MAX_CHANNELS];
  logic signed [HIST_W-1:0]  hist_o [MAX_CHANNELS];
  logic signed [HIST_W-1:0]  hist_sel;
  logic signed [HIST_W-1:0]  sat;
  logic signed [HIST_W-1:0]  sat_adj;
  logic [CH_W-1:0]           ch_idx;

  assign cfg_ready = 1'b1;
  assign stereo    = (channel_count == CC_STEREO) && (MAX_CHANNELS > 1);
  assign out_free  = !m_tvalid || m_tready;
  assign ch_idx    = CH_W'(ctrl.ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CC_MONO;
    end else if (cfg_valid) begin
      channel_count <= cfg_data;
    end
  end

  psadpcm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_new   (s_tuser),
    .stereo   (stereo),
    .out_free (out_free),
    .ctrl     (ctrl),
    .coef     (coef),
    .base     (base)
  );

  assign hist_sel = ctrl.use_older ? hist_o[ch_idx] : hist_n[ch_idx];

  psadpcm_mac u_mac (
    .clk  (clk),
    .ctrl (ctrl.mac),
    .coef (coef),
    .hist (hist_sel),
    .base (base),
    .acc  (acc)
  );

  always_comb begin
    if (acc > SAT_HI) begin
      sat = SAT_HI[HIST_W-1:0];
    end else if (acc < SAT_LO) begin
      sat = SAT_LO[HIST_W-1:0];
    end else begin
      sat = acc[HIST_W-1:0];
    end
    // Bias negative values so the shift rounds toward zero.
    sat_adj = sat + (sat[HIST_W-1] ? HIST_W'(63) : HIST_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.hist_clr) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_n[i] <= '0;
        hist_o[i] <= '0;
      end
    end else if (ctrl.hist_wr) begin
      hist_o[ch_idx] <= hist_n[ch_idx];
      hist_n[ch_idx] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.hist_wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.hist_wr) begin
      m_tdata <= sat_adj[HIST_W-1:FRAC_BITS];
      m_tuser <= ctrl.ch;
      m_tlast <= ctrl.last;
    end
  end

endmodule

/* hdl/psadpcm_chk.sv */
// ----------------------------------------------------------------------------
// psadpcm_chk
// Port-level checks of the nine-byte ADPCM decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ps_adpcm_nine_byte_decoder_defines.svh"

module psadpcm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // While the first sample of a byte waits, the second is still in work.
  `PSADPCM_ASSERT_NOW(a_busy_first, m_tvalid && !m_tlast, !s_tready, "ready with half a byte out")

  // A sample word only appears after the block was busy.
  `PSADPCM_ASSERT_NOW(a_out_busy, $rose(m_tvalid), !$past(s_tready), "sample without work")

  // Once the first sample leaves, the next word shown is the second sample of the same byte.
  `PSADPCM_ASSERT_NEXT(a_pair_order, m_tvalid && m_tready && !m_tlast, !m_tvalid || m_tlast, "second sample missing")

  `PSADPCM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled word changed")

endmodule

bind ps_adpcm_nine_byte_decoder psadpcm_chk u_chk (.*);
